// File: design/vrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_pkg
// Shared codes and types for the variable record ring FIFO: action codes,
// decoded operations, result status and the front/back transfer structs.
// ----------------------------------------------------------------------------
package vrf_pkg;

  localparam int ActionW = 3;
  localparam int LenW    = 7;
  localparam int ByteW   = 8;
  localparam int StatusW = 2;
  localparam int FreeW   = 9;
  localparam int HdrCntW = 2;

  // Action codes on the input channel
  localparam logic [ActionW-1:0] ActPutStart = 3'd0;
  localparam logic [ActionW-1:0] ActPutByte  = 3'd1;
  localparam logic [ActionW-1:0] ActTake     = 3'd2;
  localparam logic [ActionW-1:0] ActPeek     = 3'd3;
  localparam logic [ActionW-1:0] ActFlush    = 3'd4;

  typedef enum logic [2:0] {
    OP_PUT_START = 3'd0,
    OP_PUT_BYTE  = 3'd1,
    OP_TAKE      = 3'd2,
    OP_PEEK      = 3'd3,
    OP_FLUSH     = 3'd4,
    OP_NOP       = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DROP  = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             last;
    logic             empty;
    logic [FreeW-1:0] free;
  } res_t;

endpackage
`default_nettype wire

// File: design/vrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module vrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// File: design/vrf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_front
// Accepts input items, decodes the action and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module vrf_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [vrf_pkg::ActionW-1:0]  action_i,
  input  wire logic [vrf_pkg::LenW-1:0]     record_length_i,
  input  wire logic [vrf_pkg::ByteW-1:0]    data_byte_i,
  output      logic                         cmd_valid_o,
  output      vrf_pkg::cmd_t                cmd_o,
  input  wire logic                         cmd_pop_i
);
  import vrf_pkg::*;

  localparam int QDepth = 2;

  cmd_t       q_q [QDepth];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  op_e        op_dec;

  always_comb begin
    unique case (action_i)
      ActPutStart: op_dec = OP_PUT_START;
      ActPutByte:  op_dec = OP_PUT_BYTE;
      ActTake:     op_dec = OP_TAKE;
      ActPeek:     op_dec = OP_PEEK;
      ActFlush:    op_dec = OP_FLUSH;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= '{op: op_dec, len: record_length_i, data: data_byte_i};
    end
  end

endmodule
`default_nettype wire

// File: design/vrf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_back
// Carries out decoded commands on the byte ring: header writes, byte fills,
// header read and byte streaming for take/peek, flush. Results go through a
// small output queue.
// ----------------------------------------------------------------------------
module vrf_back #(
  parameter int RING_BYTES   = 256,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_RECORD   = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire vrf_pkg::cmd_t cmd_i,
  output      logic          cmd_pop_o,
  output      logic          res_valid_o,
  output      vrf_pkg::res_t res_o,
  input  wire logic          res_stall_i
);
  import vrf_pkg::*;

  localparam int AW      = $clog2(RING_BYTES);
  localparam int FW      = $clog2(RING_BYTES + 1);
  localparam int CW      = (FW > ByteW) ? FW : ByteW;
  localparam int OqDepth = 4;
  localparam int OqPtrW  = $clog2(OqDepth);
  localparam logic [AW:0]   RingW   = (AW+1)'(RING_BYTES);
  localparam logic [FW-1:0] RingF   = FW'(RING_BYTES);
  localparam logic [HdrCntW-1:0] HdrLast = HdrCntW'(HEADER_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HDR_WR = 4'b0010,
    S_LEN    = 4'b0100,
    S_DATA   = 4'b1000
  } state_e;

  function automatic logic [AW-1:0] ring_adv(input logic [AW-1:0] idx,
                                             input logic [AW:0]   n);
    logic [AW:0] sum;
    sum = {1'b0, idx} + n;
    if (sum >= RingW) begin
      sum = sum - RingW;
    end
    return sum[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [AW-1:0]       tail_q, tail_d;
  logic [FW-1:0]       free_q, free_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [HdrCntW-1:0]  hk_q, hk_d;
  logic                take_q, take_d;
  logic [LenW-1:0]     req_q, req_d;
  logic [AW-1:0]       rp_q, rp_d;
  logic [LenW-1:0]     cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [ByteW-1:0]    ram_wdata;
  logic [ByteW-1:0]    ram_rdata;

  // Output queue
  res_t                oq_q [OqDepth];
  logic [OqPtrW-1:0]   oq_wp_q, oq_rp_q;
  logic [OqPtrW:0]     oq_cnt_q;
  logic                oq_pop;
  logic                room;

  // Result being pushed
  logic                push;
  status_e             push_status;
  logic [ByteW-1:0]    push_byte;
  logic                push_bvalid;
  logic                push_last;
  res_t                push_res;

  // Datapath helpers
  logic [ByteW-1:0]    need;
  logic                put_reject;
  logic [AW:0]         fill_diff;
  logic [AW-1:0]       fill_addr;
  logic [ByteW-1:0]    stored;
  logic [ByteW-1:0]    lim_a;
  logic [ByteW-1:0]    lim;
  logic [CW:0]         free_sum;

  vrf_ram #(
    .WIDTH(ByteW),
    .DEPTH(RING_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign need       = ByteW'(HEADER_BYTES) + {1'b0, cmd_i.len};
  assign put_reject = (cmd_i.len > LenW'(MAX_RECORD)) || (CW'(free_q) < CW'(need));

  // next fill position: tail minus bytes still to come, wrapped
  always_comb begin
    fill_diff = {1'b0, tail_q} + RingW - (AW+1)'(rem_q);
    if (fill_diff >= RingW) begin
      fill_diff = fill_diff - RingW;
    end
    fill_addr = fill_diff[AW-1:0];
  end

  assign stored   = ram_rdata;
  assign lim_a    = (stored < {1'b0, req_q}) ? stored : {1'b0, req_q};
  assign lim      = (lim_a > ByteW'(MAX_RECORD)) ? ByteW'(MAX_RECORD) : lim_a;
  assign free_sum = (CW+1)'(free_q) + (CW+1)'(HEADER_BYTES) + (CW+1)'(stored);

  assign room = (oq_cnt_q + (OqPtrW+1)'(pend_q)) < (OqPtrW+1)'(OqDepth);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    rem_d       = rem_q;
    wp_d        = wp_q;
    hk_d        = hk_q;
    take_d      = take_q;
    req_d       = req_q;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = head_q;
    ram_wdata   = '0;
    cmd_pop_o   = 1'b0;
    push        = 1'b0;
    push_status = ST_OK;
    push_byte   = '0;
    push_bvalid = 1'b0;
    push_last   = 1'b1;

    // deliver the byte read last cycle
    if (pend_q) begin
      push        = 1'b1;
      push_byte   = ram_rdata;
      push_bvalid = 1'b1;
      push_last   = pend_last_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !pend_q && room) begin
          cmd_pop_o = 1'b1;
          push      = 1'b1;
          unique case (cmd_i.op)
            OP_PUT_START: begin
              rem_d = '0;
              if (put_reject) begin
                push_status = ST_FULL;
              end else begin
                tail_d  = ring_adv(tail_q, (AW+1)'(need));
                free_d  = free_q - FW'(need);
                rem_d   = cmd_i.len;
                wp_d    = tail_q;
                hk_d    = '0;
                state_d = S_HDR_WR;
              end
            end
            OP_PUT_BYTE: begin
              if (rem_q == '0) begin
                push_status = ST_DROP;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = fill_addr;
                ram_wdata = cmd_i.data;
                rem_d     = rem_q - LenW'(1);
              end
            end
            OP_TAKE, OP_PEEK: begin
              if (free_q == RingF) begin
                push_status = ST_EMPTY;
              end else begin
                // hold the result until the header is back
                push     = 1'b0;
                ram_addr = head_q;
                take_d   = (cmd_i.op == OP_TAKE);
                req_d    = cmd_i.len;
                state_d  = S_LEN;
              end
            end
            OP_FLUSH: begin
              head_d = tail_q;
              free_d = RingF;
              rem_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_HDR_WR: begin
        // low header byte holds the length, the rest are zero
        ram_we    = 1'b1;
        ram_addr  = wp_q;
        ram_wdata = (hk_q == '0) ? {1'b0, rem_q} : '0;
        wp_d      = ring_adv(wp_q, (AW+1)'(1));
        hk_d      = hk_q + HdrCntW'(1);
        if (hk_q == HdrLast) begin
          state_d = S_IDLE;
        end
      end
      S_LEN: begin
        rp_d  = ring_adv(head_q, (AW+1)'(HEADER_BYTES));
        cnt_d = lim[LenW-1:0];
        if (take_q) begin
          free_d = (free_sum > (CW+1)'(RING_BYTES)) ? RingF : FW'(free_sum);
          head_d = ring_adv(head_q, (AW+1)'(HEADER_BYTES) + (AW+1)'(stored));
        end
        if (lim == '0) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (room) begin
          ram_addr    = rp_q;
          rp_d        = ring_adv(rp_q, (AW+1)'(1));
          cnt_d       = cnt_q - LenW'(1);
          pend_d      = 1'b1;
          pend_last_d = (cnt_q == LenW'(1));
          if (cnt_q == LenW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // results always report the state after the step
  assign push_res = '{status:     push_status,
                      out_byte:   push_byte,
                      byte_valid: push_bvalid,
                      last:       push_last,
                      empty:      (free_d == RingF),
                      free:       FreeW'(free_d)};

  assign res_valid_o = (oq_cnt_q != '0);
  assign res_o       = oq_q[oq_rp_q];
  assign oq_pop      = res_valid_o && !res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= RingF;
      rem_q       <= '0;
      wp_q        <= '0;
      hk_q        <= '0;
      take_q      <= 1'b0;
      req_q       <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      oq_wp_q     <= '0;
      oq_rp_q     <= '0;
      oq_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      rem_q       <= rem_d;
      wp_q        <= wp_d;
      hk_q        <= hk_d;
      take_q      <= take_d;
      req_q       <= req_d;
      rp_q        <= rp_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      if (push) begin
        oq_wp_q <= oq_wp_q + OqPtrW'(1);
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + OqPtrW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (OqPtrW+1)'(push) - (OqPtrW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[oq_wp_q] <= push_res;
    end
  end

endmodule
`default_nettype wire

// File: design/variable_record_ring_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_record_ring_fifo_unit
// Byte ring queue of length-prefixed records with put, take, peek and flush.
// ----------------------------------------------------------------------------
// Use: present an item on the input channel (in_valid_i with action, length
// and data byte); it is taken at an edge where in_stall_o is low. Each item
// yields one result, or one result per returned byte for take/peek, on the
// output channel; last_of_run_o marks the final result of an item.
// Order: a single-result item's result enters the output queue when the back
// end accepts the item; a take/peek first reads the header and answers from
// it when no byte is returned, else it then reads each byte from the ring.
// Throughput: put_byte, flush and rejected or empty commands run at one item
// per cycle while the output queue has room; put_start holds the back end
// while it writes the header bytes through the single RAM port; take/peek
// do one ring read per returned byte, and the back end takes no new item
// until a take/peek is done.
// Reset: the queue is empty with RING_BYTES free; ring contents are not
// cleared and need no clearing pass.
// Receiver stall: results wait in a four-entry output queue; once it fills,
// the back end pauses and the two-entry command queue raises in_stall_o.
// ----------------------------------------------------------------------------
module variable_record_ring_fifo_unit #(
  parameter int RING_BYTES   = 256,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_RECORD   = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [vrf_pkg::ActionW-1:0]  action_i,
  input  wire logic [vrf_pkg::LenW-1:0]     record_length_i,
  input  wire logic [vrf_pkg::ByteW-1:0]    data_byte_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [vrf_pkg::StatusW-1:0]  status_o,
  output      logic [vrf_pkg::ByteW-1:0]    out_byte_o,
  output      logic                         byte_valid_o,
  output      logic                         last_of_run_o,
  output      logic                         queue_empty_o,
  output      logic [vrf_pkg::FreeW-1:0]    free_bytes_o
);
  import vrf_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  vrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .record_length_i(record_length_i),
    .data_byte_i    (data_byte_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  vrf_back #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_RECORD  (MAX_RECORD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(out_valid_o),
    .res_o      (res),
    .res_stall_i(out_stall_i)
  );

  assign status_o      = res.status;
  assign out_byte_o    = res.out_byte;
  assign byte_valid_o  = res.byte_valid;
  assign last_of_run_o = res.last;
  assign queue_empty_o = res.empty;
  assign free_bytes_o  = res.free;

endmodule
`default_nettype wire
